// ===== hw/rtl/escd_pkg.sv =====
// Shared constants, widths and the month start table of the seconds-to-date converter.
package escd_pkg;

   // Field widths of the two channels.
   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned SEC_W    = 6;
   localparam int unsigned MIN_W    = 6;
   localparam int unsigned HOUR_W   = 5;
   localparam int unsigned DAY_W    = 5;
   localparam int unsigned MONTH_W  = 4;
   localparam int unsigned YEAR_W   = 8;

   // Divisors of the conversion.
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned CYCLE_DAYS    = 365 * 4 + 1;

   // Widths of the intermediate values, sized from the divisors.
   localparam int unsigned DAYS_W      = EPOCH_W + 1 - $clog2(SECS_PER_DAY);
   localparam int unsigned SOD_W       = $clog2(SECS_PER_DAY);
   localparam int unsigned SOH_W       = $clog2(SECS_PER_HOUR);
   localparam int unsigned CYCLE_IDX_W = DAYS_W + 1 - $clog2(CYCLE_DAYS);
   localparam int unsigned DIC_W       = $clog2(CYCLE_DAYS);
   localparam int unsigned HOUR_Q_W    = SOD_W + 1 - $clog2(SECS_PER_HOUR);
   localparam int unsigned MIN_Q_W     = SOH_W + 1 - $clog2(SECS_PER_MIN);
   localparam int unsigned YEAR_IDX_W  = 2;
   localparam int unsigned YEARS_PER_CYCLE = 4;
   localparam int unsigned MONTHS      = 12;
   localparam int unsigned MONTH_IDX_W = 4;

   // Register stages from an accepted beat to its result.
   localparam int unsigned PIPE_DEPTH = 6;

   // First day of each month, counted from the start of the four-year cycle.
   // The first year of every cycle is a leap year.
   localparam logic [DIC_W-1:0] MONTH_START [YEARS_PER_CYCLE][MONTHS] = '{
      '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
        11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
      '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
        11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
      '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
        11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
      '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
        11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
   };

endpackage

// ===== hw/rtl/escd_cdiv.sv =====
// Two-stage divider by a constant: reciprocal multiply, then one correction step.
module escd_cdiv #(
   parameter int unsigned IN_W = 32,
   parameter int unsigned DIV  = 60,
   parameter int unsigned Q_W  = IN_W + 1 - $clog2(DIV),
   parameter int unsigned R_W  = $clog2(DIV)
) (
   input  logic            clock,
   input  logic [IN_W-1:0] dividend,
   output logic [Q_W-1:0]  quotient,
   output logic [R_W-1:0]  remainder
);

   // The scaled reciprocal underestimates the quotient by at most one.
   localparam longint unsigned MULT = (64'd1 << IN_W) / DIV;
   localparam logic [Q_W-1:0]  MULT_V = Q_W'(MULT);
   localparam logic [IN_W-1:0] DIV_V  = IN_W'(DIV);
   localparam logic [R_W:0]    DIV_R  = (R_W + 1)'(DIV);

   logic [IN_W+Q_W-1:0] product;
   logic [Q_W-1:0]      q_est_in, q_est_ff;
   logic [IN_W-1:0]     num_ff;
   logic [IN_W-1:0]     back_prod;
   logic [IN_W-1:0]     rem_wide;
   logic [R_W:0]        rem_est;
   logic [Q_W-1:0]      quotient_in, quotient_ff;
   logic [R_W-1:0]      remainder_in, remainder_ff;

   assign product  = (IN_W + Q_W)'(dividend) * (IN_W + Q_W)'(MULT_V);
   assign q_est_in = product[IN_W+Q_W-1:IN_W];

   always_ff @(posedge clock) begin
      q_est_ff <= q_est_in;
      num_ff   <= dividend;
   end

   assign back_prod = IN_W'(IN_W'(q_est_ff) * DIV_V);
   assign rem_wide  = num_ff - back_prod;
   assign rem_est   = rem_wide[R_W:0];

   always_comb begin
      if (rem_est >= DIV_R) begin
         quotient_in  = q_est_ff + Q_W'(1);
         remainder_in = R_W'(rem_est - DIV_R);
      end else begin
         quotient_in  = q_est_ff;
         remainder_in = rem_est[R_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quotient_ff  <= quotient_in;
      remainder_ff <= remainder_in;
   end

   assign quotient  = quotient_ff;
   assign remainder = remainder_ff;

endmodule

// ===== hw/rtl/escd_calendar.sv =====
// Two-stage lookup of year, month and day of month from the day within a four-year cycle.
module escd_calendar (
   input  logic                              clock,
   input  logic [escd_pkg::CYCLE_IDX_W-1:0]  cycle_idx,
   input  logic [escd_pkg::DIC_W-1:0]        day_in_cycle,
   output logic [escd_pkg::DAY_W-1:0]        day_of_month,
   output logic [escd_pkg::MONTH_W-1:0]      month_of_year,
   output logic [escd_pkg::YEAR_W-1:0]       year_offset
);
   import escd_pkg::*;

   logic [YEAR_IDX_W-1:0]  year_idx_in, year_idx_ff;
   logic [DIC_W-1:0]       dic_ff;
   logic [CYCLE_IDX_W-1:0] cycle_ff;
   logic [MONTH_IDX_W-1:0] month_idx;
   logic [DAY_W-1:0]       day_in, day_ff;
   logic [MONTH_W-1:0]     month_in, month_ff;
   logic [YEAR_W-1:0]      year_in, year_ff;

   // Year within the cycle: count the later years whose first day is reached.
   always_comb begin
      year_idx_in = '0;
      for (int k = 1; k < YEARS_PER_CYCLE; k++) begin
         year_idx_in = year_idx_in + YEAR_IDX_W'(day_in_cycle >= MONTH_START[k][0]);
      end
   end

   always_ff @(posedge clock) begin
      year_idx_ff <= year_idx_in;
      dic_ff      <= day_in_cycle;
      cycle_ff    <= cycle_idx;
   end

   // Month: the row is ascending, so the number of later months reached is the index.
   always_comb begin
      month_idx = '0;
      for (int j = 1; j < MONTHS; j++) begin
         month_idx = month_idx + MONTH_IDX_W'(dic_ff >= MONTH_START[year_idx_ff][j]);
      end
      day_in   = DAY_W'(dic_ff - MONTH_START[year_idx_ff][month_idx] + DIC_W'(1));
      month_in = MONTH_W'(month_idx + MONTH_IDX_W'(1));
      year_in  = YEAR_W'({cycle_ff, year_idx_ff});
   end

   always_ff @(posedge clock) begin
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
   end

   assign day_of_month  = day_ff;
   assign month_of_year = month_ff;
   assign year_offset   = year_ff;

endmodule

// ===== hw/rtl/epoch_seconds_to_calendar_date.sv =====
// Top level of the converter from seconds since 2000 to calendar date and time of day.
// Pipeline: six register stages from an accepted beat to its result.
// Throughput: one beat per cycle; busy is always low since the receiver cannot stall.
// The rate is set by the six-stage pipeline, in which every stage takes a new beat each cycle.
// Reset (synchronous, active high) clears the valid bits only; no beat is in flight after it.
module epoch_seconds_to_calendar_date (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [escd_pkg::EPOCH_W-1:0]       req_epoch_seconds,
   output logic                               rsp_strobe,
   output logic [escd_pkg::SEC_W-1:0]         rsp_second_of_minute,
   output logic [escd_pkg::MIN_W-1:0]         rsp_minute_of_hour,
   output logic [escd_pkg::HOUR_W-1:0]        rsp_hour_of_day,
   output logic [escd_pkg::DAY_W-1:0]         rsp_day_of_month,
   output logic [escd_pkg::MONTH_W-1:0]       rsp_month_of_year,
   output logic [escd_pkg::YEAR_W-1:0]        rsp_year_offset
);
   import escd_pkg::*;

   // Stage plan:
   //   stages 1-2: split the timestamp into whole days and seconds of the day.
   //   stages 3-4: split days into four-year cycles and day within the cycle, and
   //               seconds of the day into hour and seconds of the hour, side by side.
   //   stages 5-6: split seconds of the hour into minute and second, while the
   //               calendar unit finds year, month and day of month.
   // Every divider works by a constant reciprocal multiply followed by a single
   // compare-and-subtract correction, so each divider puts only one multiplier
   // by a constant into each of its two stages.

   logic [PIPE_DEPTH-1:0]  valid_in, valid_ff;

   logic [DAYS_W-1:0]      days;
   logic [SOD_W-1:0]       sec_of_day;
   logic [CYCLE_IDX_W-1:0] cycle_idx;
   logic [DIC_W-1:0]       day_in_cycle;
   logic [HOUR_Q_W-1:0]    hour_q;
   logic [SOH_W-1:0]       sec_of_hour;
   logic [MIN_Q_W-1:0]     minute_q;
   logic [SEC_W-1:0]       second;

   logic [HOUR_W-1:0]      hour_d1_ff, hour_d2_ff;

   // The pipeline never stalls, so a new beat is taken whenever start is high.
   assign busy = 1'b0;

   // Valid bits travel alongside the data; only these need reset.
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   escd_cdiv #(
      .IN_W (EPOCH_W),
      .DIV  (SECS_PER_DAY)
   ) u_day_div (
      .clock     (clock),
      .dividend  (req_epoch_seconds),
      .quotient  (days),
      .remainder (sec_of_day)
   );

   escd_cdiv #(
      .IN_W (DAYS_W),
      .DIV  (CYCLE_DAYS)
   ) u_cycle_div (
      .clock     (clock),
      .dividend  (days),
      .quotient  (cycle_idx),
      .remainder (day_in_cycle)
   );

   escd_cdiv #(
      .IN_W (SOD_W),
      .DIV  (SECS_PER_HOUR)
   ) u_hour_div (
      .clock     (clock),
      .dividend  (sec_of_day),
      .quotient  (hour_q),
      .remainder (sec_of_hour)
   );

   escd_cdiv #(
      .IN_W (SOH_W),
      .DIV  (SECS_PER_MIN)
   ) u_min_div (
      .clock     (clock),
      .dividend  (sec_of_hour),
      .quotient  (minute_q),
      .remainder (second)
   );

   escd_calendar u_calendar (
      .clock         (clock),
      .cycle_idx     (cycle_idx),
      .day_in_cycle  (day_in_cycle),
      .day_of_month  (rsp_day_of_month),
      .month_of_year (rsp_month_of_year),
      .year_offset   (rsp_year_offset)
   );

   // The hour is ready after stage four and waits two stages for the rest.
   always_ff @(posedge clock) begin
      hour_d1_ff <= hour_q[HOUR_W-1:0];
      hour_d2_ff <= hour_d1_ff;
   end

   assign rsp_strobe           = valid_ff[PIPE_DEPTH-1];
   assign rsp_second_of_minute = second;
   assign rsp_minute_of_hour   = minute_q[MIN_W-1:0];
   assign rsp_hour_of_day      = hour_d2_ff;

endmodule
